/* hdl/tdpe_pkg.sv */
// Package for the Thumb data-processing execute block.
// Holds the decoded-operation type, codes and constants; depends on nothing.
package tdpe_pkg;

    localparam int unsigned RegCount = 16;
    localparam int unsigned RegWidth = 32;
    localparam int unsigned QueueDepth = 2;
    localparam logic [31:0] LrRestart = 32'hFFFF_FFFF;

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusUndef = 2'd1;
    localparam logic [1:0] StatusMem = 2'd2;

    localparam logic [0:0] CfgInitialSp = 1'b0;
    localparam logic [0:0] CfgEntry = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE, OP_RESTART, OP_LSL, OP_LSR, OP_ASR, OP_ROR, OP_ADD, OP_ADC, OP_SUB, OP_SBC,
        OP_MOVI, OP_AND, OP_EOR, OP_ORR, OP_BIC, OP_MVN, OP_MUL, OP_TST, OP_NEG,
        OP_ADDH, OP_MOVH, OP_BX, OP_BLX, OP_ADR, OP_ADDSP
    } t_op;

    typedef enum logic [2:0] {
        B_REG, B_IMM, B_IMM4, B_ZERO
    } t_bsel;

    typedef struct packed {
        t_op        op;
        logic [3:0] ra;
        logic [3:0] rb;
        t_bsel      bsel;
        logic [7:0] imm;
        logic [3:0] rd;
        logic       wr;
        logic       flag_only;
        logic       sub_sp;
        logic [1:0] status;
    } t_dec;

endpackage

/* hdl/tdpe_decode.sv */
// Front part: classifies one Thumb instruction into a decoded operation.
// Depends on tdpe_pkg.
module tdpe_decode import tdpe_pkg::*; (
    input  logic        i_command,
    input  logic [15:0] i_instruction,
    output t_dec        o_dec
);
    logic [15:0] w_i;
    logic [4:0]  w_top;
    assign w_i = i_instruction;
    assign w_top = w_i[15:11];

    always_comb begin
        o_dec = '0;
        o_dec.op = OP_NONE;
        o_dec.bsel = B_REG;
        o_dec.status = StatusOk;
        if (i_command) begin
            o_dec.op = OP_RESTART;
        end else begin
            priority if (w_top <= 5'd2) begin
                unique case (w_top[1:0])
                    2'd0: o_dec.op = OP_LSL;
                    2'd1: o_dec.op = OP_LSR;
                    default: o_dec.op = OP_ASR;
                endcase
                o_dec.ra = {1'b0, w_i[5:3]};
                o_dec.bsel = B_IMM;
                o_dec.imm = {3'd0, w_i[10:6]};
                if (w_top != 5'd0 && w_i[10:6] == 5'd0) o_dec.imm = 8'd32;
                o_dec.rd = {1'b0, w_i[2:0]};
                o_dec.wr = 1'b1;
            end else if (w_top == 5'd3) begin
                o_dec.op = w_i[9] ? OP_SUB : OP_ADD;
                o_dec.ra = {1'b0, w_i[5:3]};
                o_dec.rb = {1'b0, w_i[8:6]};
                o_dec.bsel = w_i[10] ? B_IMM : B_REG;
                o_dec.imm = {5'd0, w_i[8:6]};
                o_dec.rd = {1'b0, w_i[2:0]};
                o_dec.wr = 1'b1;
            end else if (w_top <= 5'd7) begin
                o_dec.ra = {1'b0, w_i[10:8]};
                o_dec.rd = {1'b0, w_i[10:8]};
                o_dec.bsel = B_IMM;
                o_dec.imm = w_i[7:0];
                o_dec.wr = 1'b1;
                unique case (w_top[1:0])
                    2'd0: o_dec.op = OP_MOVI;
                    2'd1: begin
                        o_dec.op = OP_SUB;
                        o_dec.wr = 1'b0;
                    end
                    2'd2: o_dec.op = OP_ADD;
                    default: o_dec.op = OP_SUB;
                endcase
            end else if (w_top == 5'd8 && !w_i[10]) begin
                o_dec.ra = {1'b0, w_i[2:0]};
                o_dec.rb = {1'b0, w_i[5:3]};
                o_dec.rd = {1'b0, w_i[2:0]};
                o_dec.wr = 1'b1;
                unique case (w_i[9:6])
                    4'd0: o_dec.op = OP_AND;
                    4'd1: o_dec.op = OP_EOR;
                    4'd2: o_dec.op = OP_LSL;
                    4'd3: o_dec.op = OP_LSR;
                    4'd4: o_dec.op = OP_ASR;
                    4'd5: o_dec.op = OP_ADC;
                    4'd6: o_dec.op = OP_SBC;
                    4'd7: o_dec.op = OP_ROR;
                    4'd8: begin
                        o_dec.op = OP_TST;
                        o_dec.wr = 1'b0;
                    end
                    4'd9: o_dec.op = OP_NEG;
                    4'd10: begin
                        o_dec.op = OP_SUB;
                        o_dec.wr = 1'b0;
                    end
                    4'd11: begin
                        o_dec.op = OP_ADD;
                        o_dec.wr = 1'b0;
                    end
                    4'd12: o_dec.op = OP_ORR;
                    4'd13: o_dec.op = OP_MUL;
                    4'd14: o_dec.op = OP_BIC;
                    default: o_dec.op = OP_MVN;
                endcase
            end else if (w_top == 5'd8) begin
                o_dec.ra = {w_i[7], w_i[2:0]};
                o_dec.rb = w_i[6:3];
                o_dec.rd = {w_i[7], w_i[2:0]};
                o_dec.wr = 1'b1;
                unique case (w_i[9:8])
                    2'd0: o_dec.op = OP_ADDH;
                    2'd1: begin
                        o_dec.op = OP_SUB;
                        o_dec.wr = 1'b0;
                    end
                    2'd2: o_dec.op = OP_MOVH;
                    default: begin
                        o_dec.op = w_i[7] ? OP_BLX : OP_BX;
                        o_dec.rd = w_i[7] ? 4'd14 : 4'd15;
                    end
                endcase
            end else if (w_top <= 5'd19) begin
                o_dec.status = StatusMem;
            end else if (w_top == 5'd20) begin
                o_dec.op = OP_ADR;
                o_dec.imm = w_i[7:0];
                o_dec.rd = {1'b0, w_i[10:8]};
                o_dec.wr = 1'b1;
            end else if (w_top == 5'd21) begin
                o_dec.op = OP_ADDSP;
                o_dec.imm = w_i[7:0];
                o_dec.rd = {1'b0, w_i[10:8]};
                o_dec.wr = 1'b1;
            end else if (w_top <= 5'd23) begin
                if (w_i[15:8] == 8'hB0) begin
                    o_dec.op = OP_ADDSP;
                    o_dec.imm = {1'b0, w_i[6:0]};
                    o_dec.sub_sp = w_i[7];
                    o_dec.rd = 4'd13;
                    o_dec.wr = 1'b1;
                end else if (w_i[15:9] == 7'b1011010 || w_i[15:9] == 7'b1011110) begin
                    o_dec.status = StatusMem;
                end else begin
                    o_dec.status = StatusUndef;
                end
            end else if (w_top <= 5'd25) begin
                o_dec.status = StatusMem;
            end else begin
                o_dec.status = StatusUndef;
            end
        end
        o_dec.flag_only = (o_dec.op != OP_NONE) && !o_dec.wr;
    end
endmodule

/* hdl/tdpe_queue.sv */
// Short queue of decoded operations between the front and back parts.
// Depends on tdpe_pkg.
module tdpe_queue import tdpe_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_dec i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_dec o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_dec r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic w_push, w_pop;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_pop) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

/* hdl/tdpe_execute.sv */
// Back part: register file, flags and ALU; executes one decoded operation a cycle while i_valid is high.
// Depends on tdpe_pkg.
module tdpe_execute import tdpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_dec        i_dec,
    input  logic [31:0] i_sp_init,
    input  logic [31:0] i_entry,
    output logic        o_reg_written,
    output logic [3:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic [3:0]  o_flags_nzcv,
    output logic [31:0] o_fetch_address,
    output logic [1:0]  o_status
);
    logic [31:0] r_rf [RegCount];
    logic [3:0]  r_flags;
    logic [31:0] w_pc, w_a, w_b, w_res, w_sum_b, w_shn, w_nxt;
    logic [32:0] w_sum;
    logic [7:0]  w_n;
    logic        w_cin, w_c, w_v, w_setnz, w_setc, w_setv, w_arith;
    logic [3:0]  n_flags;
    logic [63:0] w_ext;

    assign w_pc = r_rf[15] + 32'd2;
    assign w_a = (i_dec.ra == 4'd15) ? w_pc : r_rf[i_dec.ra];

    always_comb begin
        unique case (i_dec.bsel)
            B_IMM: w_b = {24'd0, i_dec.imm};
            B_IMM4: w_b = {22'd0, i_dec.imm, 2'd0};
            B_ZERO: w_b = '0;
            default: w_b = (i_dec.rb == 4'd15) ? w_pc : r_rf[i_dec.rb];
        endcase
    end

    assign w_n = (i_dec.bsel == B_REG) ? w_b[7:0] : i_dec.imm;

    always_comb begin
        w_arith = 1'b1;
        w_sum_b = w_b;
        w_cin = 1'b0;
        unique case (i_dec.op)
            OP_SUB: begin
                w_sum_b = ~w_b;
                w_cin = 1'b1;
            end
            OP_ADC: w_cin = r_flags[1];
            OP_SBC: begin
                w_sum_b = ~w_b;
                w_cin = r_flags[1];
            end
            OP_ADD: w_cin = 1'b0;
            default: w_arith = 1'b0;
        endcase
    end

    logic [31:0] w_sa;
    assign w_sa = (i_dec.op == OP_NEG) ? ~w_b : w_a;
    assign w_sum = {1'b0, w_sa} + {1'b0, (i_dec.op == OP_NEG) ? 32'd0 : w_sum_b}
                   + {32'd0, (i_dec.op == OP_NEG) ? 1'b1 : w_cin};

    always_comb begin
        w_shn = w_a;
        w_c = r_flags[1];
        w_ext = '0;
        if (w_n != 8'd0) begin
            unique case (i_dec.op)
                OP_LSL: begin
                    if (w_n < 8'd32) begin
                        w_ext = {32'd0, w_a} << w_n[4:0];
                        w_shn = w_ext[31:0];
                        w_c = w_ext[32];
                    end else begin
                        w_shn = '0;
                        w_c = (w_n == 8'd32) ? w_a[0] : 1'b0;
                    end
                end
                OP_LSR, OP_ASR: begin
                    if (w_n < 8'd32) begin
                        w_ext = {{31{(i_dec.op == OP_ASR) & w_a[31]}}, w_a, 1'b0} >>
                                w_n[4:0];
                        w_shn = w_ext[32:1];
                        w_c = w_ext[0];
                    end else if (i_dec.op == OP_ASR) begin
                        w_shn = {32{w_a[31]}};
                        w_c = w_a[31];
                    end else begin
                        w_shn = '0;
                        w_c = (w_n == 8'd32) ? w_a[31] : 1'b0;
                    end
                end
                default: begin
                    w_ext = {w_a, w_a} >> w_n[4:0];
                    w_shn = w_ext[31:0];
                    w_c = w_shn[31];
                end
            endcase
        end
    end

    always_comb begin
        w_setnz = 1'b1;
        w_setc = 1'b0;
        w_setv = 1'b0;
        unique case (i_dec.op)
            OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
                w_res = w_shn;
                w_setc = 1'b1;
            end
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_NEG: begin
                w_res = w_sum[31:0];
                w_setc = 1'b1;
                w_setv = 1'b1;
            end
            OP_MOVI: w_res = w_b;
            OP_AND, OP_TST: w_res = w_a & w_b;
            OP_EOR: w_res = w_a ^ w_b;
            OP_ORR: w_res = w_a | w_b;
            OP_BIC: w_res = w_a & ~w_b;
            OP_MVN: w_res = ~w_b;
            OP_MUL: w_res = w_a * w_b;
            OP_ADDH: begin
                w_res = w_a + w_b;
                w_setnz = 1'b0;
            end
            OP_MOVH, OP_BX: begin
                w_res = w_b;
                w_setnz = 1'b0;
            end
            OP_BLX: begin
                w_res = r_rf[15] | 32'd1;
                w_setnz = 1'b0;
            end
            OP_ADR: begin
                w_res = {w_pc[31:2], 2'b00} + {22'd0, i_dec.imm, 2'd0};
                w_setnz = 1'b0;
            end
            OP_ADDSP: begin
                w_res = i_dec.sub_sp ? r_rf[13] - {22'd0, i_dec.imm, 2'd0}
                                     : r_rf[13] + {22'd0, i_dec.imm, 2'd0};
                w_setnz = 1'b0;
            end
            default: begin
                w_res = '0;
                w_setnz = 1'b0;
            end
        endcase
    end

    logic [32:0] w_vsb;
    assign w_vsb = {1'b0, (i_dec.op == OP_NEG) ? 32'd0 : w_sum_b};
    assign w_v = (~(w_sa[31] ^ w_vsb[31])) & (w_sa[31] ^ w_sum[31]);

    always_comb begin
        n_flags = r_flags;
        if (w_setnz) begin
            n_flags[3] = w_res[31];
            n_flags[2] = (w_res == '0);
        end
        if (w_setc) n_flags[1] = w_arith || i_dec.op == OP_NEG ? w_sum[32] : w_c;
        if (w_setv) n_flags[0] = w_v;
    end

    logic [31:0] w_wval;
    logic        w_pcw;
    assign w_pcw = i_dec.wr && i_dec.rd == 4'd15;
    assign w_wval = w_pcw ? {w_res[31:1], 1'b0} : w_res;

    always_comb begin
        if (i_dec.op == OP_RESTART) w_nxt = i_entry + 32'd2;
        else if (i_dec.op == OP_BLX) w_nxt = {w_b[31:1], 1'b0} + 32'd2;
        else if (w_pcw) w_nxt = w_wval + 32'd2;
        else w_nxt = w_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RegCount; k++) r_rf[k] <= '0;
            r_flags <= '0;
        end else if (i_valid) begin
            r_flags <= n_flags;
            r_rf[15] <= w_nxt;
            if (i_dec.op == OP_RESTART) begin
                r_rf[13] <= i_sp_init;
                r_rf[14] <= LrRestart;
            end else if (i_dec.wr && i_dec.rd != 4'd15) begin
                r_rf[i_dec.rd] <= w_wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            o_reg_written <= i_dec.wr;
            o_dest_index <= i_dec.wr ? i_dec.rd : 4'd0;
            o_dest_value <= i_dec.wr ? w_wval : 32'd0;
            o_flags_nzcv <= n_flags;
            o_fetch_address <= w_nxt - 32'd2;
            o_status <= i_dec.status;
        end
    end
endmodule

/* hdl/thumb_data_processing_execute.sv */
// Top level of the Thumb data-processing execute block.
// Depends on tdpe_pkg, tdpe_decode, tdpe_queue and tdpe_execute.
//
//   channel   direction  handshake          payload
//   input     in         push / full        i_command, i_instruction
//   result    out        empty / pop        six result fields
//   config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle sustained while each result is popped; a result passes
// through the queue and the result register and can then be popped.
// The back stage executes one operation per cycle out of a two-entry queue and
// advances only while the one-entry result register is free or being popped.
// Synchronous reset clears the register file, flags and all queue pointers.
module thumb_data_processing_execute import tdpe_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [15:0] i_instruction,
    output logic        empty,
    input  logic        pop,
    output logic        o_reg_written,
    output logic [3:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic [3:0]  o_flags_nzcv,
    output logic [31:0] o_fetch_address,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_dec w_dec, w_qdec;
    logic w_qempty, w_go, r_out_valid;
    logic [31:0] r_sp_init, r_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_init <= '0;
            r_entry <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgInitialSp: r_sp_init <= i_cfg_data;
                default: r_entry <= i_cfg_data;
            endcase
        end
    end

    tdpe_decode u_decode (
        .i_command(i_command),
        .i_instruction(i_instruction),
        .o_dec(w_dec)
    );

    tdpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data(w_dec),
        .o_full(full),
        .i_pop(w_go),
        .o_empty(w_qempty),
        .o_data(w_qdec)
    );

    assign w_go = !w_qempty && (!r_out_valid || pop);
    assign empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_go) r_out_valid <= 1'b1;
        else if (pop) r_out_valid <= 1'b0;
    end

    tdpe_execute u_execute (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_go),
        .i_dec(w_qdec),
        .i_sp_init(r_sp_init),
        .i_entry(r_entry),
        .o_reg_written(o_reg_written),
        .o_dest_index(o_dest_index),
        .o_dest_value(o_dest_value),
        .o_flags_nzcv(o_flags_nzcv),
        .o_fetch_address(o_fetch_address),
        .o_status(o_status)
    );
endmodule
